// ===== design/dmxr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dmxr_pkg;

	// Line samples per 4 us DMX bit.
	localparam int DEFAULT_SAMPLES_PER_BIT = 4;

	localparam int TICK_W  = 10;
	localparam int FRAME_W = 10;
	localparam int BIT_W   = 4;
	localparam int DATA_W  = 8;
	localparam int CFG_W   = 10;
	localparam int IDX_W   = 3;

	localparam logic [TICK_W-1:0] CNT_MAX = '1;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_CHANNEL   = 3'd0;
	localparam logic [IDX_W-1:0] REG_ON_THRESH = 3'd1;
	localparam logic [IDX_W-1:0] REG_OFF_LEVEL = 3'd2;
	localparam logic [IDX_W-1:0] REG_BREAK_MIN = 3'd3;
	localparam logic [IDX_W-1:0] REG_MAB_MIN   = 3'd4;

	// Register reset values.
	localparam logic [9:0] RST_CHANNEL   = 10'd53;
	localparam logic [7:0] RST_ON_THRESH = 8'd100;
	localparam logic [7:0] RST_OFF_LEVEL = 8'd0;
	localparam logic [9:0] RST_BREAK_MIN = 10'd88;
	localparam logic [7:0] RST_MAB_MIN   = 8'd8;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_BREAK = 3'd1,
		PH_MAB   = 3'd2,
		PH_FRAME = 3'd3,
		PH_HUNT  = 3'd4
	} dmxr_phase_t;

	// A completed capture of the selected slot.
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] data;
	} dmxr_cap_t;

	// Saturating increment for tick and frame counters.
	function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + 10'd1;
	endfunction

endpackage

`default_nettype wire

// ===== design/dmxr_frame.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmxr_frame #(
	parameter int SAMPLES_PER_BIT = dmxr_pkg::DEFAULT_SAMPLES_PER_BIT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic                         level,
	input  wire logic [dmxr_pkg::CFG_W-1:0]   channel,
	input  wire logic [dmxr_pkg::CFG_W-1:0]   break_min,
	input  wire logic [dmxr_pkg::DATA_W-1:0]  mab_min,
	output dmxr_pkg::dmxr_cap_t               cap
);
	import dmxr_pkg::*;

	localparam int StopTicks = 9 * SAMPLES_PER_BIT + SAMPLES_PER_BIT / 2;

	dmxr_phase_t         phase_q, phase_d;
	logic [TICK_W-1:0]   tick_q, tick_d;
	logic [BIT_W-1:0]    bit_q, bit_d;
	logic [FRAME_W-1:0]  frame_q, frame_d;
	logic [DATA_W-1:0]   shift_q, shift_d;
	logic [TICK_W-1:0]   tick_inc;
	logic [TICK_W-1:0]   sample_at;
	logic [DATA_W-1:0]   shift_in;

	assign tick_inc  = sat_inc(tick_q);
	assign shift_in  = {level, shift_q[DATA_W-1:1]};
	// Middle of data bit bit_q, counted from the falling edge of the start bit.
	assign sample_at = TICK_W'((int'(bit_q) + 1) * SAMPLES_PER_BIT + SAMPLES_PER_BIT / 2);

	// Phase register and counters advance once per accepted line sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			frame_q <= '0;
			shift_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			frame_q <= frame_d;
			shift_q <= shift_d;
		end
	end

	// Break, mark-after-break and character framing.
	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		bit_d     = bit_q;
		frame_d   = frame_q;
		shift_d   = shift_q;
		cap.valid = 1'b0;
		cap.data  = shift_in;
		unique case (phase_q)
			PH_BREAK: begin
				if (!level) begin
					tick_d = tick_inc;
				end else if (tick_q >= break_min) begin
					phase_d = PH_MAB;
					tick_d  = 10'd1;
				end else begin
					phase_d = PH_IDLE;
					tick_d  = '0;
				end
			end
			PH_MAB: begin
				if (level) begin
					tick_d = tick_inc;
				end else if (tick_q >= {2'b00, mab_min}) begin
					frame_d = '0;
					phase_d = PH_FRAME;
					tick_d  = '0;
					bit_d   = '0;
				end else begin
					phase_d = PH_IDLE;
					tick_d  = '0;
				end
			end
			PH_FRAME: begin
				tick_d = tick_inc;
				if (bit_q < 4'd8) begin
					if (tick_inc == sample_at) begin
						shift_d = shift_in;
						bit_d   = bit_q + 4'd1;
						if (bit_q == 4'd7 && frame_q == channel) begin
							cap.valid = 1'b1;
							phase_d   = PH_IDLE;
							tick_d    = '0;
							bit_d     = '0;
						end
					end
				end else if (tick_inc >= TICK_W'(StopTicks)) begin
					phase_d = PH_HUNT;
					tick_d  = '0;
					bit_d   = '0;
				end
			end
			PH_HUNT: begin
				if (!level) begin
					frame_d = sat_inc(frame_q);
					phase_d = PH_FRAME;
					tick_d  = '0;
					bit_d   = '0;
				end
			end
			default: begin
				if (!level) begin
					phase_d = PH_BREAK;
					tick_d  = 10'd1;
				end else begin
					phase_d = PH_IDLE;
					tick_d  = '0;
				end
			end
		endcase
	end

	// The bit index only runs inside a character.
	a_bit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_FRAME) |-> (bit_q == '0))
		else $error("bit index nonzero outside a character");

	// Idle always holds a cleared tick count.
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (tick_q == '0))
		else $error("tick count nonzero in idle");

	// A capture ends the packet and returns to idle.
	a_cap_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && cap.valid) |=> (phase_q == PH_IDLE))
		else $error("capture did not return to idle");

endmodule

`default_nettype wire

// ===== design/dmx_slot_receiver_with_hysteresis.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Single-slot DMX512 receiver with a hysteresis lamp output.
// The input channel carries one line sample per request (line_level, 1 is
// mark), at SAMPLES_PER_BIT samples per 4 us bit. Every accepted sample
// produces exactly one request on the output channel carrying lamp_on,
// slot_value and value_valid, the latter high only for the sample that
// completes the eighth data bit of the selected slot.
// The state update and the result are registered at the edge that accepts
// the sample. Throughput is one sample per cycle while the output is taken;
// the single result register lets a new sample in at the same edge that
// the waiting result is taken.
// When the output stalls, in_ready drops and the result holds until taken.
// The configuration port writes register cfg_index (0 to 4) on any edge with cfg_we high;
// write only while no result is pending.
// Reset puts the framer in idle, clears the captured value, turns the lamp
// off, loads the register defaults (slot 53, on above 100, off at or below
// 0, break 88 samples, mark-after-break 8 samples) and empties the output.
module dmx_slot_receiver_with_hysteresis #(
	parameter int SAMPLES_PER_BIT = dmxr_pkg::DEFAULT_SAMPLES_PER_BIT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         line_level,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              lamp_on,
	output logic [dmxr_pkg::DATA_W-1:0]       slot_value,
	output logic                              value_valid,
	input  wire logic                         cfg_we,
	input  wire logic [dmxr_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [dmxr_pkg::CFG_W-1:0]   cfg_data
);
	import dmxr_pkg::*;

	logic [CFG_W-1:0]  channel_q;
	logic [DATA_W-1:0] on_thresh_q;
	logic [DATA_W-1:0] off_level_q;
	logic [CFG_W-1:0]  break_min_q;
	logic [DATA_W-1:0] mab_min_q;
	logic              out_valid_q;
	logic              lamp_q;
	logic [DATA_W-1:0] value_q;
	logic              vvalid_q;
	logic              step;
	dmxr_cap_t         cap;

	assign in_ready    = !out_valid_q || out_ready;
	assign step        = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign lamp_on     = lamp_q;
	assign slot_value  = value_q;
	assign value_valid = vvalid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q   <= RST_CHANNEL;
			on_thresh_q <= RST_ON_THRESH;
			off_level_q <= RST_OFF_LEVEL;
			break_min_q <= RST_BREAK_MIN;
			mab_min_q   <= RST_MAB_MIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHANNEL:   channel_q   <= cfg_data;
				REG_ON_THRESH: on_thresh_q <= cfg_data[DATA_W-1:0];
				REG_OFF_LEVEL: off_level_q <= cfg_data[DATA_W-1:0];
				REG_BREAK_MIN: break_min_q <= cfg_data;
				REG_MAB_MIN:   mab_min_q   <= cfg_data[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	dmxr_frame #(
		.SAMPLES_PER_BIT(SAMPLES_PER_BIT)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.level     (line_level),
		.channel   (channel_q),
		.break_min (break_min_q),
		.mab_min   (mab_min_q),
		.cap       (cap)
	);

	// Result register: captured value and lamp state double as the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			lamp_q      <= 1'b0;
			value_q     <= '0;
			vvalid_q    <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
			vvalid_q    <= cap.valid;
			if (cap.valid) begin
				value_q <= cap.data;
				// The on test wins when the two thresholds overlap.
				if (cap.data > on_thresh_q) begin
					lamp_q <= 1'b1;
				end else if (cap.data <= off_level_q) begin
					lamp_q <= 1'b0;
				end
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// An accepted capture is presented on the next cycle.
	a_cap_out: assert property (@(posedge clk) disable iff (!arst_n)
		(step && cap.valid) |=> (out_valid && value_valid))
		else $error("capture not presented");

	// Captured state only changes with an accepted sample.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(lamp_on) && $stable(slot_value)))
		else $error("state changed without a sample");

	// The lamp switches on only through a capture.
	a_lamp_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(lamp_on) |-> $past(step && cap.valid))
		else $error("lamp rose without a capture");

endmodule

`default_nettype wire
